// ===== sv/ieps_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes of the I2C EEPROM page sequencer.
// No dependencies; used by ieps_step and i2c_eeprom_page_sequencer_core.
package ieps_pkg;

	localparam int MAX_RESULTS = 4;

	// func codes of an input transfer
	localparam logic [1:0] FUNC_WRITE_REQ = 2'd0;
	localparam logic [1:0] FUNC_READ_REQ  = 2'd1;
	localparam logic [1:0] FUNC_WDATA     = 2'd2;
	localparam logic [1:0] FUNC_REPORT    = 2'd3;

	// bus command codes
	localparam logic [2:0] OP_START = 3'd0;
	localparam logic [2:0] OP_STOP  = 3'd1;
	localparam logic [2:0] OP_SEND  = 3'd2;
	localparam logic [2:0] OP_RACK  = 3'd3;
	localparam logic [2:0] OP_RNACK = 3'd4;

	// host response codes
	localparam logic [1:0] HOST_RDATA   = 2'd0;
	localparam logic [1:0] HOST_DONE    = 2'd1;
	localparam logic [1:0] HOST_TIMEOUT = 2'd2;

	localparam logic KIND_BUS  = 1'b0;
	localparam logic KIND_HOST = 1'b1;

	// sequencer phases
	localparam logic [3:0] PH_IDLE  = 4'd0;
	localparam logic [3:0] PH_POLL  = 4'd1;
	localparam logic [3:0] PH_WDATA = 4'd2;
	localparam logic [3:0] PH_RDEV  = 4'd3;
	localparam logic [3:0] PH_RDATA = 4'd4;

	// configuration register indexes
	localparam logic REG_DEVICE_ADDRESS = 1'b0;
	localparam logic REG_RETRY_LIMIT    = 1'b1;

	localparam logic [7:0] DEVICE_ADDRESS_RST = 8'd160;
	localparam logic [7:0] RETRY_LIMIT_RST    = 8'd100;

	typedef struct packed {
		logic [1:0]  func;
		logic [15:0] req_address;
		logic [15:0] req_length;
		logic [7:0]  write_data;
		logic        bus_ack;
		logic [7:0]  bus_read_data;
	} in_item_t;

	typedef struct packed {
		logic       kind;
		logic [2:0] bus_op;
		logic [7:0] bus_byte;
		logic [1:0] host_code;
		logic [7:0] host_data;
		logic       last;
	} out_item_t;

	// all results caused by one input transfer
	typedef struct packed {
		logic [2:0]                        count;
		out_item_t [MAX_RESULTS-1:0] item;
	} result_set_t;

	function automatic out_item_t mk_bus(input logic [2:0] op, input logic [7:0] b);
		out_item_t r;
		r          = '0;
		r.kind     = KIND_BUS;
		r.bus_op   = op;
		r.bus_byte = b;
		return r;
	endfunction

	function automatic out_item_t mk_host(input logic [1:0] code, input logic [7:0] d);
		out_item_t r;
		r           = '0;
		r.kind      = KIND_HOST;
		r.host_code = code;
		r.host_data = d;
		return r;
	endfunction

endpackage

// ===== sv/ieps_step.sv =====
`timescale 1ns / 1ps
// Next-state and result logic of the page sequencer for one input transfer.
// Depends on ieps_pkg.
module ieps_step import ieps_pkg::*; #(
	parameter int PAGE_BYTES = 128,
	parameter int ADDR_BITS  = 16
) (
	input  in_item_t              item,
	input  logic [7:0]            dev_addr,
	input  logic [7:0]            retry_limit,
	input  logic [3:0]            phase,
	input  logic [ADDR_BITS-1:0]  cur_address,
	input  logic [15:0]           bytes_left,
	input  logic [7:0]            poll_count,
	input  logic                  is_read,
	input  logic                  final_seg,
	output logic [3:0]            phase_nx,
	output logic [ADDR_BITS-1:0]  cur_address_nx,
	output logic [15:0]           bytes_left_nx,
	output logic [7:0]            poll_count_nx,
	output logic                  is_read_nx,
	output logic                  final_seg_nx,
	output result_set_t           results
);

	// PAGE_BYTES is a power of two; the page offset is the low address bits
	localparam logic [ADDR_BITS-1:0] PAGE_MASK = ADDR_BITS'(PAGE_BYTES - 1);

	logic [ADDR_BITS-1:0] addr_inc;
	logic [ADDR_BITS-1:0] addr_inc2;
	logic [15:0]          bytes_dec;
	logic [15:0]          addr_wide;
	logic [7:0]           poll_inc;
	logic                 page_end1;
	logic                 page_end2;

	assign addr_inc  = cur_address + ADDR_BITS'(1);
	assign addr_inc2 = cur_address + ADDR_BITS'(2);
	assign bytes_dec = bytes_left - 16'd1;
	assign addr_wide = 16'(cur_address);
	assign poll_inc  = poll_count + 8'd1;
	assign page_end1 = (addr_inc & PAGE_MASK) == '0;
	assign page_end2 = (addr_inc2 & PAGE_MASK) == '0;

	always_comb begin
		logic [2:0] n;
		n              = 3'd0;
		results        = '0;
		phase_nx       = phase;
		cur_address_nx = cur_address;
		bytes_left_nx  = bytes_left;
		poll_count_nx  = poll_count;
		is_read_nx     = is_read;
		final_seg_nx   = final_seg;

		unique case (item.func)
			FUNC_WRITE_REQ, FUNC_READ_REQ: begin
				if (phase == PH_IDLE) begin
					if (item.req_length == 16'd0) begin
						results.item[n[1:0]] = mk_host(HOST_DONE, 8'h00);
						n = n + 3'd1;
					end else begin
						cur_address_nx = item.req_address[ADDR_BITS-1:0];
						bytes_left_nx  = item.req_length;
						is_read_nx     = (item.func == FUNC_READ_REQ);
						final_seg_nx   = 1'b0;
						poll_count_nx  = 8'd0;
						results.item[n[1:0]] = mk_bus(OP_START, 8'h00);
						n = n + 3'd1;
						results.item[n[1:0]] = mk_bus(OP_SEND, dev_addr);
						n = n + 3'd1;
						phase_nx = PH_POLL;
					end
				end
			end
			FUNC_WDATA: begin
				if (phase == PH_WDATA) begin
					results.item[n[1:0]] = mk_bus(OP_SEND, item.write_data);
					n = n + 3'd1;
					cur_address_nx = addr_inc;
					bytes_left_nx  = bytes_dec;
					if (page_end1 || bytes_dec == 16'd0) begin
						results.item[n[1:0]] = mk_bus(OP_STOP, 8'h00);
						n = n + 3'd1;
						if (bytes_dec == 16'd0) begin
							results.item[n[1:0]] = mk_host(HOST_DONE, 8'h00);
							n = n + 3'd1;
							phase_nx = PH_IDLE;
						end else begin
							poll_count_nx = 8'd0;
							results.item[n[1:0]] = mk_bus(OP_START, 8'h00);
							n = n + 3'd1;
							results.item[n[1:0]] = mk_bus(OP_SEND, dev_addr);
							n = n + 3'd1;
							phase_nx = PH_POLL;
						end
					end
				end
			end
			FUNC_REPORT: begin
				unique case (phase)
					PH_POLL: begin
						if (item.bus_ack) begin
							results.item[n[1:0]] = mk_bus(OP_SEND, addr_wide[15:8]);
							n = n + 3'd1;
							results.item[n[1:0]] = mk_bus(OP_SEND, addr_wide[7:0]);
							n = n + 3'd1;
							if (is_read) begin
								results.item[n[1:0]] = mk_bus(OP_START, 8'h00);
								n = n + 3'd1;
								results.item[n[1:0]] = mk_bus(OP_SEND, dev_addr | 8'h01);
								n = n + 3'd1;
								phase_nx = PH_RDEV;
							end else begin
								phase_nx = PH_WDATA;
							end
						end else begin
							poll_count_nx = poll_inc;
							if (poll_inc == retry_limit) begin
								// timeout leaves the bus without a stop
								results.item[n[1:0]] = mk_host(HOST_TIMEOUT, 8'h00);
								n = n + 3'd1;
								phase_nx = PH_IDLE;
							end else begin
								results.item[n[1:0]] = mk_bus(OP_STOP, 8'h00);
								n = n + 3'd1;
								results.item[n[1:0]] = mk_bus(OP_START, 8'h00);
								n = n + 3'd1;
								results.item[n[1:0]] = mk_bus(OP_SEND, dev_addr);
								n = n + 3'd1;
							end
						end
					end
					PH_RDEV: begin
						final_seg_nx = page_end1 || bytes_left <= 16'd1;
						results.item[n[1:0]] = mk_bus(final_seg_nx ? OP_RNACK : OP_RACK, 8'h00);
						n = n + 3'd1;
						phase_nx = PH_RDATA;
					end
					PH_RDATA: begin
						results.item[n[1:0]] = mk_host(HOST_RDATA, item.bus_read_data);
						n = n + 3'd1;
						cur_address_nx = addr_inc;
						bytes_left_nx  = bytes_dec;
						if (final_seg) begin
							results.item[n[1:0]] = mk_bus(OP_STOP, 8'h00);
							n = n + 3'd1;
							if (bytes_dec == 16'd0) begin
								results.item[n[1:0]] = mk_host(HOST_DONE, 8'h00);
								n = n + 3'd1;
								phase_nx = PH_IDLE;
							end else begin
								poll_count_nx = 8'd0;
								results.item[n[1:0]] = mk_bus(OP_START, 8'h00);
								n = n + 3'd1;
								results.item[n[1:0]] = mk_bus(OP_SEND, dev_addr);
								n = n + 3'd1;
								phase_nx = PH_POLL;
							end
						end else begin
							// next read of the same segment
							final_seg_nx = page_end2 || bytes_dec <= 16'd1;
							results.item[n[1:0]] =
								mk_bus(final_seg_nx ? OP_RNACK : OP_RACK, 8'h00);
							n = n + 3'd1;
						end
					end
					default: begin
					end
				endcase
			end
			default: begin
			end
		endcase

		for (int i = 0; i < MAX_RESULTS; i++) begin
			if (3'(i) + 3'd1 == n) begin
				results.item[i].last = 1'b1;
			end
		end
		results.count = n;
	end

endmodule

// ===== sv/i2c_eeprom_page_sequencer_core.sv =====
`timescale 1ns / 1ps
// Top level of the I2C EEPROM page sequencer: state, config and output queue.
// Depends on ieps_pkg and ieps_step.
//
// Use: the cmd channel carries host requests, write data bytes and bus reports
// from the byte engine (func selects which). The rsp channel returns bus
// commands for the byte engine and host responses, tagged by kind; last marks
// the final result caused by one cmd transfer. Up to four results follow one
// transfer; some transfers cause none.
// Config: cfg_we writes cfg_data into device_address (index 0) or
// retry_limit (index 1) at once; write only while the block is idle.
// Order: the results of a transfer are computed in the accept cycle and stored
// in the output or hold register, sent one per cycle while rsp_ready is high.
// Throughput: one cmd transfer per cycle with rsp_ready high while each
// causes at most one result; else the rsp side paces it, one result per cycle.
// A two-deep result-set queue (output register plus one hold register)
// lets a transfer be taken while a finished result still waits.
// Stall: when rsp_ready stays low, results hold and cmd_ready drops once the
// hold register is full. Reset clears the sequencer to idle, empties the queue
// and loads device_address 160 and retry_limit 100.
module i2c_eeprom_page_sequencer_core import ieps_pkg::*; #(
	parameter int PAGE_BYTES = 128,
	parameter int ADDR_BITS  = 16
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      cmd_valid,
	output logic      cmd_ready,
	input  in_item_t  cmd_data,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output out_item_t rsp_data,
	input  logic      cfg_we,
	input  logic      cfg_index,
	input  logic [7:0] cfg_data
);

	logic [7:0]           dev_addr_q;
	logic [7:0]           retry_q;
	logic [3:0]           phase_q;
	logic [ADDR_BITS-1:0] cur_address_q;
	logic [15:0]          bytes_left_q;
	logic [7:0]           poll_count_q;
	logic                 is_read_q;
	logic                 final_seg_q;

	logic [3:0]           phase_nx;
	logic [ADDR_BITS-1:0] cur_address_nx;
	logic [15:0]          bytes_left_nx;
	logic [7:0]           poll_count_nx;
	logic                 is_read_nx;
	logic                 final_seg_nx;
	result_set_t          step_set;

	// result-set queue
	out_item_t [MAX_RESULTS-1:0] hold_items_q;
	logic [2:0]                  hold_cnt_q;
	logic                        hold_vld_q;
	out_item_t [MAX_RESULTS-1:0] out_items_q;
	logic [2:0]                  out_rem_q;
	logic [1:0]                  out_idx_q;

	logic cmd_xfer;
	logic rsp_xfer;
	logic out_free;
	logic new_set;

	ieps_step #(
		.PAGE_BYTES(PAGE_BYTES),
		.ADDR_BITS (ADDR_BITS)
	) u_step (
		.item          (cmd_data),
		.dev_addr      (dev_addr_q),
		.retry_limit   (retry_q),
		.phase         (phase_q),
		.cur_address   (cur_address_q),
		.bytes_left    (bytes_left_q),
		.poll_count    (poll_count_q),
		.is_read       (is_read_q),
		.final_seg     (final_seg_q),
		.phase_nx      (phase_nx),
		.cur_address_nx(cur_address_nx),
		.bytes_left_nx (bytes_left_nx),
		.poll_count_nx (poll_count_nx),
		.is_read_nx    (is_read_nx),
		.final_seg_nx  (final_seg_nx),
		.results       (step_set)
	);

	assign cmd_ready = !hold_vld_q;
	assign cmd_xfer  = cmd_valid && cmd_ready;
	assign rsp_valid = out_rem_q != 3'd0;
	assign rsp_data  = out_items_q[out_idx_q];
	assign rsp_xfer  = rsp_valid && rsp_ready;
	assign out_free  = (out_rem_q == 3'd0) || (out_rem_q == 3'd1 && rsp_ready);
	assign new_set   = cmd_xfer && step_set.count != 3'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEVICE_ADDRESS_RST;
			retry_q    <= RETRY_LIMIT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_DEVICE_ADDRESS: dev_addr_q <= cfg_data;
				REG_RETRY_LIMIT:    retry_q    <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			cur_address_q <= '0;
			bytes_left_q  <= '0;
			poll_count_q  <= '0;
			is_read_q     <= 1'b0;
			final_seg_q   <= 1'b0;
		end else if (cmd_xfer) begin
			phase_q       <= phase_nx;
			cur_address_q <= cur_address_nx;
			bytes_left_q  <= bytes_left_nx;
			poll_count_q  <= poll_count_nx;
			is_read_q     <= is_read_nx;
			final_seg_q   <= final_seg_nx;
		end
	end

	// queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_vld_q <= 1'b0;
			hold_cnt_q <= '0;
			out_rem_q  <= '0;
			out_idx_q  <= '0;
		end else if (out_free) begin
			out_idx_q <= '0;
			if (hold_vld_q) begin
				// advance the held set; a new set cannot arrive while hold is full
				out_rem_q  <= hold_cnt_q;
				hold_vld_q <= 1'b0;
			end else if (new_set) begin
				out_rem_q <= step_set.count;
			end else begin
				out_rem_q <= '0;
			end
		end else begin
			if (rsp_xfer) begin
				out_rem_q <= out_rem_q - 3'd1;
				out_idx_q <= out_idx_q + 2'd1;
			end
			if (new_set) begin
				hold_vld_q <= 1'b1;
				hold_cnt_q <= step_set.count;
			end
		end
	end

	// queue payload
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (hold_vld_q) begin
				out_items_q <= hold_items_q;
			end else if (new_set) begin
				out_items_q <= step_set.item;
			end
		end else if (new_set) begin
			hold_items_q <= step_set.item;
		end
	end

endmodule

// ===== sim/tb_i2c_eeprom_page_sequencer_core.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for i2c_eeprom_page_sequencer_core: a directed run,
// then random request/report traffic under several register settings.
// Depends on ieps_pkg and the sequencer RTL; needs no files or arguments.
module tb_i2c_eeprom_page_sequencer_core;
	import ieps_pkg::*;

	localparam int PAGE_BYTES = 128;
	localparam int IDLE_PCT   = 31;

	typedef struct packed {
		logic [3:0]  phase;
		logic [15:0] addr;
		logic [15:0] left;
		logic [7:0]  polls;
		logic        is_read;
		logic        final_seg;
		logic [7:0]  dev;
		logic [7:0]  retries;
	} seq_state_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_ready;
	in_item_t   cmd_data = '0;
	logic       rsp_valid;
	logic       rsp_ready = 1'b0;
	out_item_t  rsp_data;
	logic       cfg_we = 1'b0;
	logic       cfg_index = 1'b0;
	logic [7:0] cfg_data = '0;

	i2c_eeprom_page_sequencer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd_data  (cmd_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp_data  (rsp_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// model_seq follows accepted transfers; plan_seq runs ahead to shape stimulus
	seq_state_t  model_seq;
	seq_state_t  plan_seq;
	result_set_t model_out;
	in_item_t    pending_cmds[$];
	out_item_t   due_results[$];
	int          n_queued = 0;
	int          n_accepted = 0;
	int          n_results = 0;
	int          errors = 0;
	int          hold_left = 0;
	bit          held_once = 1'b0;
	bit          steady = 1'b0;

	initial forever #5 clk = ~clk;

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	// ---------------- sequencer prediction ----------------

	function automatic seq_state_t reset_state();
		seq_state_t s;
		s         = '0;
		s.phase   = PH_IDLE;
		s.dev     = DEVICE_ADDRESS_RST;
		s.retries = RETRY_LIMIT_RST;
		return s;
	endfunction

	function automatic void put_bus(inout result_set_t rs, input logic [2:0] op,
			input logic [7:0] b);
		out_item_t r;
		r          = '0;
		r.kind     = KIND_BUS;
		r.bus_op   = op;
		r.bus_byte = b;
		rs.item[rs.count] = r;
		rs.count++;
	endfunction

	function automatic void put_host(inout result_set_t rs, input logic [1:0] code,
			input logic [7:0] d);
		out_item_t r;
		r           = '0;
		r.kind      = KIND_HOST;
		r.host_code = code;
		r.host_data = d;
		rs.item[rs.count] = r;
		rs.count++;
	endfunction

	function automatic void open_segment(inout seq_state_t s, inout result_set_t rs);
		s.polls = '0;
		put_bus(rs, OP_START, 8'h00);
		put_bus(rs, OP_SEND, s.dev);
		s.phase = PH_POLL;
	endfunction

	function automatic void step_addr(inout seq_state_t s);
		s.left = s.left - 16'd1;
		s.addr = s.addr + 16'd1;
	endfunction

	// nack the byte that ends the page or the request
	function automatic void request_read(inout seq_state_t s, inout result_set_t rs);
		logic [15:0] nxt;
		nxt = s.addr + 16'd1;
		s.final_seg = (nxt % PAGE_BYTES) == 0 || s.left <= 16'd1;
		put_bus(rs, s.final_seg ? OP_RNACK : OP_RACK, 8'h00);
		s.phase = PH_RDATA;
	endfunction

	function automatic void close_segment(inout seq_state_t s, inout result_set_t rs);
		put_bus(rs, OP_STOP, 8'h00);
		if (s.left == 16'd0) begin
			put_host(rs, HOST_DONE, 8'h00);
			s.phase = PH_IDLE;
		end else begin
			open_segment(s, rs);
		end
	endfunction

	function automatic result_set_t sequencer_step(inout seq_state_t s, input in_item_t it);
		result_set_t rs;
		rs = '0;
		case (it.func)
			FUNC_WRITE_REQ, FUNC_READ_REQ: begin
				if (s.phase == PH_IDLE) begin
					if (it.req_length == 16'd0) begin
						put_host(rs, HOST_DONE, 8'h00);
					end else begin
						s.addr      = it.req_address;
						s.left      = it.req_length;
						s.is_read   = (it.func == FUNC_READ_REQ);
						s.final_seg = 1'b0;
						open_segment(s, rs);
					end
				end
			end
			FUNC_WDATA: begin
				if (s.phase == PH_WDATA) begin
					put_bus(rs, OP_SEND, it.write_data);
					step_addr(s);
					if ((s.addr % PAGE_BYTES) == 0 || s.left == 16'd0)
						close_segment(s, rs);
				end
			end
			default: begin
				case (s.phase)
					PH_POLL: begin
						if (it.bus_ack) begin
							put_bus(rs, OP_SEND, s.addr[15:8]);
							put_bus(rs, OP_SEND, s.addr[7:0]);
							if (s.is_read) begin
								put_bus(rs, OP_START, 8'h00);
								put_bus(rs, OP_SEND, s.dev | 8'h01);
								s.phase = PH_RDEV;
							end else begin
								s.phase = PH_WDATA;
							end
						end else begin
							// polls wraps at 8 bits, so a limit of zero means 256 tries
							s.polls = s.polls + 8'd1;
							if (s.polls == s.retries) begin
								put_host(rs, HOST_TIMEOUT, 8'h00);
								s.phase = PH_IDLE;
							end else begin
								put_bus(rs, OP_STOP, 8'h00);
								put_bus(rs, OP_START, 8'h00);
								put_bus(rs, OP_SEND, s.dev);
							end
						end
					end
					PH_RDEV: begin
						request_read(s, rs);
					end
					PH_RDATA: begin
						put_host(rs, HOST_RDATA, it.bus_read_data);
						step_addr(s);
						if (s.final_seg)
							close_segment(s, rs);
						else
							request_read(s, rs);
					end
					default: ;
				endcase
			end
		endcase
		if (rs.count != 0)
			rs.item[rs.count - 1].last = 1'b1;
		return rs;
	endfunction

	// ---------------- stimulus building ----------------

	// fields the command does not use still carry random bits
	function automatic in_item_t random_item(input logic [1:0] f);
		in_item_t it;
		it.func          = f;
		it.req_address   = 16'($urandom);
		it.req_length    = 16'($urandom);
		it.write_data    = 8'($urandom);
		it.bus_ack       = 1'($urandom);
		it.bus_read_data = 8'($urandom);
		return it;
	endfunction

	task automatic queue_cmd(input in_item_t it);
		void'(sequencer_step(plan_seq, it));
		pending_cmds.push_back(it);
		n_queued++;
	endtask

	task automatic send_req(input logic [1:0] f, input logic [15:0] a, input logic [15:0] l);
		in_item_t it;
		it             = random_item(f);
		it.req_address = a;
		it.req_length  = l;
		queue_cmd(it);
	endtask

	task automatic send_data(input logic [7:0] d);
		in_item_t it;
		it            = random_item(FUNC_WDATA);
		it.write_data = d;
		queue_cmd(it);
	endtask

	task automatic send_report(input logic ack, input logic [7:0] rd);
		in_item_t it;
		it               = random_item(FUNC_REPORT);
		it.bus_ack       = ack;
		it.bus_read_data = rd;
		queue_cmd(it);
	endtask

	// next transfer the sequencer is waiting for
	task automatic queue_next(input int nack_pct);
		logic [15:0] a;
		logic [15:0] l;
		int          r;
		case (plan_seq.phase)
			PH_IDLE: begin
				r = $urandom_range(0, 99);
				if (r < 35)
					a = (16'($urandom) | 16'h007F) - 16'($urandom_range(0, 3));
				else if (r < 45)
					a = 16'hFFFF - 16'($urandom_range(0, 5));
				else
					a = 16'($urandom);
				r = $urandom_range(0, 99);
				if (r < 6)
					l = 16'd0;
				else if (r < 9)
					l = 16'($urandom_range(100, 200));
				else
					l = 16'($urandom_range(1, 6));
				send_req($urandom_range(0, 1) ? FUNC_READ_REQ : FUNC_WRITE_REQ, a, l);
			end
			PH_POLL:  send_report($urandom_range(0, 99) >= nack_pct, 8'($urandom));
			PH_WDATA: send_data(8'($urandom));
			default:  send_report(1'($urandom), 8'($urandom));
		endcase
	endtask

	// transfers the sequencer ignores in its present phase
	task automatic queue_noise();
		if (plan_seq.phase == PH_IDLE) begin
			queue_cmd(random_item($urandom_range(0, 1) ? FUNC_WDATA : FUNC_REPORT));
		end else if ($urandom_range(0, 1)) begin
			queue_cmd(random_item($urandom_range(0, 1) ? FUNC_READ_REQ : FUNC_WRITE_REQ));
		end else begin
			queue_cmd(random_item(plan_seq.phase == PH_WDATA ? FUNC_REPORT : FUNC_WDATA));
		end
	endtask

	task automatic run_random(input int count, input int nack_pct);
		int n;
		n = 0;
		while (n < count) begin
			if ($urandom_range(0, 99) < 10) begin
				queue_noise();
			end else begin
				queue_next(nack_pct);
				n++;
			end
		end
		// finish the open request so the next register write finds the block idle
		while (plan_seq.phase != PH_IDLE)
			queue_next(nack_pct);
	endtask

	task automatic drain();
		while (n_accepted != n_queued || due_results.size() != 0)
			@(posedge clk);
		repeat (5) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [7:0] v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DEVICE_ADDRESS) begin
			model_seq.dev = v;
			plan_seq.dev  = v;
		end else begin
			model_seq.retries = v;
			plan_seq.retries  = v;
		end
	endtask

	// ---------------- command driver ----------------

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_valid <= 1'b0;
			cmd_data  <= '0;
		end else begin
			if (cmd_valid && cmd_ready) begin
				model_out = sequencer_step(model_seq, cmd_data);
				for (int i = 0; i < model_out.count; i++)
					due_results.push_back(model_out.item[i]);
				n_accepted++;
			end
			if (cmd_valid && !cmd_ready) begin
				// hold the offered transfer
			end else if (pending_cmds.size() != 0 &&
					(steady || $urandom_range(0, 99) >= IDLE_PCT)) begin
				cmd_valid <= 1'b1;
				cmd_data  <= pending_cmds.pop_front();
			end else begin
				cmd_valid <= 1'b0;
			end
		end
	end

	// ---------------- result monitor ----------------

	function automatic int mismatch(input string fname, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", fname, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				n_results++;
				if (due_results.size() == 0) begin
					$error("result with nothing expected: kind %0d op %0d byte %0d code %0d",
						rsp_data.kind, rsp_data.bus_op, rsp_data.bus_byte, rsp_data.host_code);
					errors++;
				end else begin
					out_item_t want;
					want = due_results.pop_front();
					errors += mismatch("kind", want.kind, rsp_data.kind)
						+ mismatch("bus_op", want.bus_op, rsp_data.bus_op)
						+ mismatch("bus_byte", want.bus_byte, rsp_data.bus_byte)
						+ mismatch("host_code", want.host_code, rsp_data.host_code)
						+ mismatch("host_data", want.host_data, rsp_data.host_data)
						+ mismatch("last", want.last, rsp_data.last);
				end
			end
			if (hold_left != 0) begin
				hold_left--;
				rsp_ready <= 1'b0;
			end else if (!held_once && n_results >= 40 && pending_cmds.size() > 20) begin
				// stall long enough to back the sequencer up into cmd_ready
				held_once = 1'b1;
				hold_left = 80;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= steady || $urandom_range(0, 99) >= IDLE_PCT;
			end
		end
	end

	// ---------------- test sequence ----------------

	initial begin
		model_seq = reset_state();
		plan_seq  = reset_state();
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// stray transfers while idle
		send_report(1'b1, 8'hFF);
		send_data(8'hFF);
		// zero-length requests answer done at once
		send_req(FUNC_WRITE_REQ, 16'hFFFF, 16'd0);
		send_req(FUNC_READ_REQ, 16'h0000, 16'd0);
		// write across a page boundary, with a nack, a busy request and strays
		send_req(FUNC_WRITE_REQ, 16'h007E, 16'd3);
		send_report(1'b0, 8'h00);
		send_req(FUNC_READ_REQ, 16'hFFFF, 16'hFFFF);
		send_data(8'h55);
		send_report(1'b1, 8'h00);
		send_report(1'b0, 8'h00);
		send_data(8'h00);
		send_data(8'hFF);
		send_report(1'b1, 8'hFF);
		send_data(8'hA5);
		// read that wraps the address past the top and crosses a page
		send_req(FUNC_READ_REQ, 16'hFFFF, 16'd2);
		send_report(1'b1, 8'h00);
		send_report(1'b0, 8'h00);
		send_report(1'b0, 8'hFF);
		send_report(1'b1, 8'h00);
		send_report(1'b1, 8'h00);
		send_report(1'b0, 8'h00);
		drain();

		write_reg(REG_DEVICE_ADDRESS, 8'd0);
		write_reg(REG_RETRY_LIMIT, 8'd1);
		run_random(40, 20);
		drain();

		write_reg(REG_DEVICE_ADDRESS, 8'd254);
		write_reg(REG_RETRY_LIMIT, 8'd255);
		run_random(40, 30);
		drain();

		steady = 1'b1;
		write_reg(REG_DEVICE_ADDRESS, 8'hA6);
		write_reg(REG_RETRY_LIMIT, 8'd3);
		run_random(40, 40);
		drain();
		steady = 1'b0;

		write_reg(REG_DEVICE_ADDRESS, 8'($urandom_range(0, 254)));
		write_reg(REG_RETRY_LIMIT, 8'd2);
		run_random(40, 35);
		drain();

		$display("Checked %0d results from %0d commands, %0d mismatches.",
			n_results, n_accepted, errors);
		$display("Covered page crossings, address wrap, poll retries and timeouts, strays.");
		if (errors == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
